// ===== design/ffdt_pkg.sv =====
// Shared types, constants and helpers for the float to decimal text formatter.
`timescale 1ns / 1ps
package ffdt_pkg;

	localparam int MAX_DIGITS_DEF = 6;
	localparam int BCD_DIGITS = 20;
	localparam logic [63:0] SCALE_LIMIT = 64'd9000000000000000000;
	localparam logic [7:0] CAP_MIN = 8'd4;
	localparam logic [5:0] INT_DIGITS_MAX = 6'd9;
	localparam logic [7:0] EXP_SPECIAL = 8'hFF;

	typedef struct packed {
		logic [31:0] value_bits;
		logic [3:0]  frac_digits;
		logic [7:0]  field_capacity;
	} req_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last_char;
		logic [4:0] text_length;
		logic       no_text;
	} res_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic shift;
		logic chk;
		logic conv;
		logic eval;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic fixed_text;
		logic ovf;
		logic d_zero;
		logic conv_last;
		logic fit;
		logic emit_last;
	} sta_t;

	function automatic logic [29:0] pow10(input logic [3:0] d);
		case (d)
			4'd0: pow10 = 30'd1;
			4'd1: pow10 = 30'd10;
			4'd2: pow10 = 30'd100;
			4'd3: pow10 = 30'd1000;
			4'd4: pow10 = 30'd10000;
			4'd5: pow10 = 30'd100000;
			4'd6: pow10 = 30'd1000000;
			4'd7: pow10 = 30'd10000000;
			4'd8: pow10 = 30'd100000000;
			4'd9: pow10 = 30'd1000000000;
			default: pow10 = 30'd0;
		endcase
	endfunction

endpackage

// ===== design/ffdt_ctrl.sv =====
// Controller state machine sequencing scale, conversion, fit check and emission.
`timescale 1ns / 1ps
module ffdt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            result_valid,
	output ffdt_pkg::cmd_t  cmd,
	input  ffdt_pkg::sta_t  sta
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SEL, ST_MUL, ST_SHIFT, ST_CHK, ST_CONV, ST_EVAL, ST_EMIT
	} state_t;

	state_t state_q;
	logic   strobe_q;

	assign busy = (state_q != ST_IDLE);
	assign result_valid = strobe_q;

	always_comb begin
		cmd = '0;
		cmd.load  = (state_q == ST_IDLE) && start;
		cmd.mul   = (state_q == ST_MUL);
		cmd.shift = (state_q == ST_SHIFT);
		cmd.chk   = (state_q == ST_CHK);
		cmd.conv  = (state_q == ST_CONV);
		cmd.eval  = (state_q == ST_EVAL);
		cmd.emit  = (state_q == ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_EMIT);
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_SEL;
				end
				ST_SEL: begin
					state_q <= sta.fixed_text ? ST_EMIT : ST_MUL;
				end
				ST_MUL: state_q <= ST_SHIFT;
				ST_SHIFT: state_q <= ST_CHK;
				ST_CHK: begin
					if (!sta.ovf) state_q <= ST_CONV;
					else if (sta.d_zero) state_q <= ST_EMIT;
					else state_q <= ST_MUL;
				end
				ST_CONV: begin
					if (sta.conv_last) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= (sta.fit || sta.d_zero) ? ST_EMIT : ST_MUL;
				end
				ST_EMIT: begin
					if (sta.emit_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/ffdt_datapath.sv =====
// Datapath: scaling (rounded on right shifts), binary to BCD conversion, fit check and character output.
`timescale 1ns / 1ps
module ffdt_datapath #(
	parameter int MAX_DIGITS = ffdt_pkg::MAX_DIGITS_DEF
) (
	input  logic            clk,
	input  ffdt_pkg::req_t  request,
	output ffdt_pkg::res_t  result,
	input  ffdt_pkg::cmd_t  cmd,
	output ffdt_pkg::sta_t  sta
);

	typedef enum logic [1:0] {M_NUM, M_SMALL, M_DASH, M_OVF} mode_t;

	localparam logic [3:0] DMAX = 4'(MAX_DIGITS);
	localparam int BW = 4 * ffdt_pkg::BCD_DIGITS;

	mode_t              mode_q;
	logic [23:0]        m_q;
	logic signed [8:0]  s_q;
	logic               neg_q;
	logic [3:0]         d_q;
	logic [7:0]         cap_q;
	logic [53:0]        p_q;
	logic [63:0]        units_q;
	logic               ovf_q;
	logic [63:0]        bin_q;
	logic [BW-1:0]      bcd_q;
	logic [3:0]         cnt_q;
	logic [4:0]         k_q;
	logic [4:0]         len_q;
	logic [5:0]         ipd_q;
	logic               sign_q;
	ffdt_pkg::res_t     res_q;

	logic [7:0]  e_in;
	logic [63:0] units_n;
	logic        ovf_n;
	logic [63:0] lim;
	logic [8:0]  tneg;
	logic [5:0]  sh;
	logic [63:0] bin_n;
	logic [BW-1:0] bcd_n;
	logic [5:0]  nd;
	logic [5:0]  ipd;
	logic [5:0]  d6;
	logic [5:0]  need;
	logic        sgn;
	logic [4:0]  nres;
	logic [5:0]  j;
	logic [5:0]  pos;
	logic [3:0]  dig;
	logic [7:0]  ch;

	assign e_in = request.value_bits[30:23];

	always_comb begin
		units_n = '0;
		ovf_n = 1'b0;
		lim = '0;
		tneg = 9'(-s_q);
		sh = tneg[5:0];
		if (p_q != '0) begin
			if (!s_q[8]) begin
				if (s_q >= 9'sd64) begin
					ovf_n = 1'b1;
				end else begin
					lim = (ffdt_pkg::SCALE_LIMIT - 64'd1) >> s_q[5:0];
					ovf_n = {10'd0, p_q} > lim;
					units_n = {10'd0, p_q} << s_q[5:0];
				end
			end else if (tneg < 9'd64) begin
				units_n = ({10'd0, p_q} + (64'd1 << (sh - 6'd1))) >> sh;
			end
		end
	end

	always_comb begin
		bin_n = bin_q;
		bcd_n = bcd_q;
		for (int i = 0; i < 4; i++) begin
			for (int g = 0; g < ffdt_pkg::BCD_DIGITS; g++) begin
				if (bcd_n[4*g +: 4] >= 4'd5) bcd_n[4*g +: 4] = bcd_n[4*g +: 4] + 4'd3;
			end
			bcd_n = {bcd_n[BW-2:0], bin_n[63]};
			bin_n = {bin_n[62:0], 1'b0};
		end
	end

	always_comb begin
		nd = '0;
		for (int g = 0; g < ffdt_pkg::BCD_DIGITS; g++) begin
			if (bcd_q[4*g +: 4] != 4'd0) nd = 6'(g + 1);
		end
		d6 = {2'd0, d_q};
		ipd = (nd > d6) ? (nd - d6) : 6'd1;
		sgn = neg_q && (nd != 6'd0);
		need = {5'd0, sgn} + ipd + ((d_q != 4'd0) ? (d6 + 6'd1) : 6'd0);
	end

	always_comb begin
		nres = (mode_q == M_SMALL) ? 5'd1 : len_q;
		j = {1'b0, k_q} - {5'd0, sign_q};
		pos = '0;
		ch = 8'd0;
		case (mode_q)
			M_SMALL: ch = 8'd0;
			M_DASH:  ch = "-";
			M_OVF: begin
				case (k_q)
					5'd0: ch = "O";
					5'd1: ch = "V";
					default: ch = "F";
				endcase
			end
			default: begin
				if (sign_q && (k_q == 5'd0)) begin
					ch = "-";
				end else if (j == ipd_q) begin
					ch = ".";
				end else begin
					if (j < ipd_q) pos = ipd_q + {2'd0, d_q} - 6'd1 - j;
					else pos = ipd_q + {2'd0, d_q} - j;
					ch = "0" + {4'd0, dig};
				end
			end
		endcase
	end

	assign dig = bcd_q[4*pos[4:0] +: 4];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cap_q <= request.field_capacity;
			neg_q <= request.value_bits[31];
			m_q <= {(e_in != 8'd0), request.value_bits[22:0]};
			s_q <= (e_in == 8'd0) ? -9'sd149 : ($signed({1'b0, e_in}) - 9'sd150);
			d_q <= (request.frac_digits > DMAX) ? DMAX : request.frac_digits;
			k_q <= '0;
			len_q <= 5'd3;
			if (request.field_capacity < ffdt_pkg::CAP_MIN) mode_q <= M_SMALL;
			else if (e_in == ffdt_pkg::EXP_SPECIAL) mode_q <= M_DASH;
			else mode_q <= M_NUM;
		end
		if (cmd.mul) p_q <= m_q * ffdt_pkg::pow10(d_q);
		if (cmd.shift) begin
			units_q <= units_n;
			ovf_q <= ovf_n;
		end
		if (cmd.chk) begin
			bin_q <= units_q;
			bcd_q <= '0;
			cnt_q <= '0;
			if (ovf_q) begin
				if (d_q == 4'd0) mode_q <= M_DASH;
				else d_q <= d_q - 4'd1;
			end
		end
		if (cmd.conv) begin
			bin_q <= bin_n;
			bcd_q <= bcd_n;
			cnt_q <= cnt_q + 4'd1;
		end
		if (cmd.eval) begin
			if ({2'd0, need} < cap_q) begin
				ipd_q <= ipd;
				sign_q <= sgn;
				if (ipd > ffdt_pkg::INT_DIGITS_MAX) begin
					mode_q <= M_OVF;
					len_q <= 5'd3;
				end else begin
					mode_q <= M_NUM;
					len_q <= need[4:0];
				end
			end else if (d_q == 4'd0) begin
				mode_q <= M_OVF;
				len_q <= 5'd3;
			end else begin
				d_q <= d_q - 4'd1;
			end
		end
		if (cmd.emit) begin
			k_q <= k_q + 5'd1;
			res_q.text_char <= ch;
			res_q.last_char <= (k_q == nres - 5'd1);
			res_q.text_length <= (mode_q == M_SMALL) ? 5'd0 : len_q;
			res_q.no_text <= (mode_q == M_SMALL);
		end
	end

	assign result = res_q;

	always_comb begin
		sta.fixed_text = (mode_q != M_NUM);
		sta.ovf = ovf_q;
		sta.d_zero = (d_q == 4'd0);
		sta.conv_last = (cnt_q == 4'd15);
		sta.fit = ({2'd0, need} < cap_q);
		sta.emit_last = (k_q == nres - 5'd1);
	end

endmodule

// ===== design/float_to_fitted_decimal_text_top.sv =====
// Top level of the float32 to fitted fixed-point decimal text formatter.
// Sequence: small capacity or NaN/infinity go straight to emission; else each digit count
// converted runs multiply, shift, check, 16 BCD steps and fit, and each count skipped on
// scale overflow runs multiply, shift and check only; then one character per cycle.
// Throughput: one item at a time; busy stays high until the last character is issued.
// Reset: arst_n asynchronously returns the controller to idle with no result pending.
`timescale 1ns / 1ps
module float_to_fitted_decimal_text_top #(
	parameter int MAX_DIGITS = ffdt_pkg::MAX_DIGITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ffdt_pkg::req_t  request,
	output logic            result_valid,
	output ffdt_pkg::res_t  result
);

	ffdt_pkg::cmd_t cmd;
	ffdt_pkg::sta_t sta;

	ffdt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.result_valid (result_valid),
		.cmd          (cmd),
		.sta          (sta)
	);

	ffdt_datapath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk     (clk),
		.request (request),
		.result  (result),
		.cmd     (cmd),
		.sta     (sta)
	);

endmodule

// ===== tb/float_to_fitted_decimal_text_top_test.sv =====
// Self-checking testbench for the float32 to fitted decimal text formatter.
`timescale 1ns / 1ps
module float_to_fitted_decimal_text_top_test;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [63:0] HUGE_LIMIT = 64'd9000000000000000000;
	localparam logic [63:0] INT_LIMIT = 64'd1000000000;

	class text_scoreboard;
		ffdt_pkg::res_t expected_chars[$];

		function bit scale_magnitude(input logic [31:0] m, input int s, input int d,
				output logic [63:0] units);
			logic [63:0] p;
			int t;
			p = {32'd0, m};
			for (int i = 0; i < d; i++) p = p * 64'd10;
			units = '0;
			if (p == 0) return 1;
			if (s >= 0) begin
				if (s >= 64) return 0;
				if (p > ((HUGE_LIMIT - 64'd1) >> s)) return 0;
				units = p << s;
				return 1;
			end
			t = -s;
			if (t < 64) units = (p + (64'd1 << (t - 1))) >> t;
			return 1;
		endfunction

		function void note_item(input ffdt_pkg::req_t r);
			string txt, fs, is;
			logic [7:0] e;
			logic [22:0] f;
			logic [31:0] m;
			logic [63:0] units, pw, ip, fp;
			int s, digits, need;
			bit neg, sign, done;
			ffdt_pkg::res_t c;
			if (r.field_capacity < ffdt_pkg::CAP_MIN) begin
				c = '{text_char: 8'd0, last_char: 1'b1, text_length: 5'd0, no_text: 1'b1};
				expected_chars.push_back(c);
				return;
			end
			digits = (r.frac_digits > 6) ? 6 : r.frac_digits;
			e = r.value_bits[30:23];
			f = r.value_bits[22:0];
			neg = r.value_bits[31];
			m = (e == 0) ? {9'd0, f} : {9'd1, f};
			s = (e == 0) ? -149 : int'(e) - 150;
			done = 0;
			txt = "OVF";
			if (e == ffdt_pkg::EXP_SPECIAL || !scale_magnitude(m, s, 0, units)) begin
				txt = "---";
				done = 1;
			end
			for (int d = digits; d >= 0 && !done; d--) begin
				if (!scale_magnitude(m, s, d, units)) continue;
				pw = 64'd1;
				for (int i = 0; i < d; i++) pw = pw * 64'd10;
				ip = units / pw;
				fp = units % pw;
				sign = neg && units != 0;
				is = $sformatf("%0d", ip);
				need = sign + is.len() + ((d > 0) ? d + 1 : 0);
				if (need + 1 > r.field_capacity) continue;
				done = 1;
				if (ip >= INT_LIMIT) break;
				fs = $sformatf("%0d", fp);
				while (fs.len() < d) fs = {"0", fs};
				txt = is;
				if (d > 0) txt = {txt, ".", fs};
				if (sign) txt = {"-", txt};
			end
			for (int k = 0; k < txt.len(); k++) begin
				c.text_char = txt[k];
				c.last_char = (k == txt.len() - 1);
				c.text_length = 5'(txt.len());
				c.no_text = 1'b0;
				expected_chars.push_back(c);
			end
		endfunction

		function bit check_char(input ffdt_pkg::res_t got, output string msg);
			ffdt_pkg::res_t x;
			x = expected_chars.pop_front();
			msg = "";
			if (got.text_char !== x.text_char)
				msg = $sformatf("text_char got %h exp %h", got.text_char, x.text_char);
			else if (got.last_char !== x.last_char)
				msg = $sformatf("last_char got %b exp %b", got.last_char, x.last_char);
			else if (got.text_length !== x.text_length)
				msg = $sformatf("text_length got %0d exp %0d", got.text_length, x.text_length);
			else if (got.no_text !== x.no_text)
				msg = $sformatf("no_text got %b exp %b", got.no_text, x.no_text);
			return msg == "";
		endfunction
	endclass

	logic clk, arst_n, start, busy, result_valid;
	ffdt_pkg::req_t request;
	ffdt_pkg::res_t result;
	text_scoreboard sb;
	int errors, items_in, chars_out, idle_cycles, gap_pct;
	string msg;

	float_to_fitted_decimal_text_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .result_valid(result_valid), .result(result)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_item(request);
			items_in++;
		end
		if (arst_n && result_valid) begin
			chars_out++;
			if (sb.expected_chars.size() == 0) report("character with none expected");
			else if (!sb.check_char(result, msg)) report(msg);
		end
		if ((start && !busy) || result_valid || !arst_n) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d characters pending", sb.expected_chars.size());
			$display("float_to_fitted_decimal_text_top verification failed");
			$finish;
		end
	end

	task automatic send_item(input logic [31:0] bits, input logic [3:0] fd, input logic [7:0] cap);
		while ($urandom_range(99) < gap_pct) begin
			start = 0;
			@(negedge clk);
		end
		start = 1;
		request = '{value_bits: bits, frac_digits: fd, field_capacity: cap};
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 0;
	endtask

	task automatic send_random();
		logic [31:0] bits;
		logic [7:0] cap;
		bits = $urandom;
		if ($urandom_range(99) < 75) bits[30:23] = 8'($urandom_range(90, 200));
		case ($urandom_range(9))
			0: cap = 8'($urandom);
			1: cap = 8'($urandom_range(3));
			default: cap = 8'($urandom_range(4, 20));
		endcase
		send_item(bits, 4'($urandom), cap);
	endtask

	initial begin
		sb = new();
		errors = 0;
		items_in = 0;
		chars_out = 0;
		idle_cycles = 0;
		gap_pct = 31;
		start = 0;
		request = '0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_item(32'h0000_0000, 4'd2, 8'd8);
		send_item(32'h8000_0000, 4'd3, 8'd8);
		send_item(32'h7FC0_0000, 4'd2, 8'd8);
		send_item(32'h7F80_0000, 4'd2, 8'd8);
		send_item(32'hFF80_0000, 4'd2, 8'd255);
		send_item(32'h5EF9_CCD9, 4'd0, 8'd255);
		send_item(32'h5EF9_CCD8, 4'd0, 8'd255);
		send_item(32'h7F7F_FFFF, 4'd6, 8'd255);
		send_item(32'h0000_0001, 4'd15, 8'd255);
		send_item(32'h807F_FFFF, 4'd6, 8'd12);
		send_item(32'h3FC0_0000, 4'd0, 8'd8);
		send_item(32'hBFC0_0000, 4'd0, 8'd8);
		send_item(32'hBA03_126F, 4'd3, 8'd8);
		send_item(32'h4E6E_6B28, 4'd2, 8'd255);
		send_item(32'h4E6E_6B27, 4'd0, 8'd255);
		send_item(32'h4996_B438, 4'd6, 8'd9);
		send_item(32'h4996_B438, 4'd6, 8'd4);
		send_item(32'hC2F6_E979, 4'd15, 8'd5);
		send_item(32'h3F80_0000, 4'd6, 8'd3);
		send_item(32'h3F80_0000, 4'd6, 8'd0);
		send_item(32'hFFFF_FFFF, 4'd9, 8'd255);
		send_item(32'h3DCC_CCCD, 4'd6, 8'd4);

		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 31 : (ph == 1) ? 67 : 0;
			repeat (83) send_random();
		end

		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d items (directed extremes and specials, then random across three",
			items_in);
		$display("sender gap settings); checked %0d output characters.", chars_out);
		if (errors == 0 && sb.expected_chars.size() == 0)
			$display("float_to_fitted_decimal_text_top verification clean");
		else
			$display("float_to_fitted_decimal_text_top verification failed");
		$finish;
	end
endmodule
